@@ design/markup_tag_stripper_macros.svh @@
// Assertion helpers included by the stripper top module.
`ifndef MARKUP_TAG_STRIPPER_MACROS_SVH
`define MARKUP_TAG_STRIPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MKS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is high.
`define MKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

@@ design/mks_pkg.sv @@
package mks_pkg;

   localparam int WinLen = 8;

   localparam logic [7:0] CharLt    = 8'h3C;
   localparam logic [7:0] CharGt    = 8'h3E;
   localparam logic [7:0] CharSpace = 8'h20;

   localparam logic [47:0] NameScript    = "script";
   localparam logic [39:0] NameStyle     = "style";
   localparam logic [55:0] NameEndScript = "/script";
   localparam logic [47:0] NameEndStyle  = "/style";

   // index 0 is the oldest byte, index WinLen-1 the newest
   typedef logic [WinLen-1:0][7:0] win_type;

   typedef struct packed {
      logic enter;
      logic leave;
   } match_type;

   typedef struct packed {
      logic busy;
      logic full;
   } buf_status_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   function automatic logic is_space_byte(input logic [7:0] c);
      return (c == CharSpace) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

endpackage

@@ design/mks_match.sv @@
module mks_match (
   input  mks_pkg::win_type   win,
   output mks_pkg::match_type hit
);
   import mks_pkg::*;

   win_type fold;
   logic    hit_script;
   logic    hit_style;
   logic    hit_end_script;
   logic    hit_end_style;

   always_comb begin
      for (int k = 0; k < WinLen; k++) begin
         fold[k] = fold_case(win[k]);
      end
      hit_script     = (win[1] == CharLt);
      hit_end_style  = (win[1] == CharLt);
      hit_style      = (win[2] == CharLt);
      hit_end_script = (win[0] == CharLt);
      for (int k = 0; k < 6; k++) begin
         hit_script    = hit_script    && (fold[2 + k] == NameScript[8 * (5 - k) +: 8]);
         hit_end_style = hit_end_style && (fold[2 + k] == NameEndStyle[8 * (5 - k) +: 8]);
      end
      for (int k = 0; k < 5; k++) begin
         hit_style = hit_style && (fold[3 + k] == NameStyle[8 * (4 - k) +: 8]);
      end
      for (int k = 0; k < 7; k++) begin
         hit_end_script = hit_end_script && (fold[1 + k] == NameEndScript[8 * (6 - k) +: 8]);
      end
      hit.enter = hit_script || hit_style;
      hit.leave = hit_end_script || hit_end_style;
   end

endmodule

@@ design/mks_out_buf.sv @@
module mks_out_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [7:0]                  in_byte,
   output logic                        out_valid,
   output logic [7:0]                  out_byte,
   input  logic                        out_stall,
   output mks_pkg::buf_status_type     status
);
   import mks_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic [7:0] main_ff, main_in;
   logic [7:0] skid_ff, skid_in;
   logic       take;

   assign take = main_valid_ff && !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take && skid_valid_ff) begin
         // promote the parked beat
         main_in       = skid_ff;
         skid_valid_in = 1'b0;
      end else if (take || !main_valid_ff) begin
         main_valid_in = in_valid;
         main_in       = in_byte;
      end else if (in_valid) begin
         // head is stalled: park the new beat
         skid_valid_in = 1'b1;
         skid_in       = in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid   = main_valid_ff;
   assign out_byte    = main_ff;
   assign status.busy = main_valid_ff;
   assign status.full = skid_valid_ff;

endmodule

@@ design/markup_tag_stripper.sv @@
// Output: a surviving byte is registered in the output buffer before it shows on the result port.
// Throughput: one input beat per cycle, with the two-entry output buffer; input
//   stalls only while both output entries are full.
// Reset: synchronous, active high; clears tag, script and whitespace flags, the
//   eight-byte window and the output buffer.
module markup_tag_stripper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_start_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_plain_byte
);
   import mks_pkg::*;
   `include "markup_tag_stripper_macros.svh"

   // parser state, advanced once per accepted beat
   logic    tag_ff, tag_in;
   logic    script_ff, script_in;
   logic    prev_ff, prev_in;
   win_type win_ff, win_in;

   // state as seen by this beat, after the start flag is applied
   logic    tag_cur;
   logic    script_cur;
   logic    prev_cur;
   win_type win_cur;

   match_type      hit;
   buf_status_type buf_status;

   logic       accept;
   logic       delim;
   logic       survives;
   logic [7:0] kept;
   logic       emit;
   logic [7:0] emit_byte;

   assign accept = req_valid && !req_stall;

   // start of text wipes everything before this byte is looked at
   always_comb begin
      if (req_start_of_text) begin
         tag_cur    = 1'b0;
         script_cur = 1'b0;
         prev_cur   = 1'b0;
         win_cur    = '0;
      end else begin
         tag_cur    = tag_ff;
         script_cur = script_ff;
         prev_cur   = prev_ff;
         win_cur    = win_ff;
      end
   end

   mks_match u_match (
      .win (win_cur),
      .hit (hit)
   );

   always_comb begin
      delim = (req_text_byte == CharGt) || (req_text_byte == CharSpace);

      // a tag name closed by '>' or space flips script mode first
      script_in = script_cur;
      if (delim && hit.enter) begin
         script_in = 1'b1;
      end
      if (delim && hit.leave) begin
         script_in = 1'b0;
      end

      tag_in   = tag_cur;
      survives = 1'b0;
      kept     = req_text_byte;
      if (req_text_byte == CharLt) begin
         tag_in = 1'b1;
      end else if (req_text_byte == CharGt) begin
         // closing mark turns into a space outside script blocks
         tag_in   = 1'b0;
         survives = !script_in;
         kept     = CharSpace;
      end else begin
         survives = !tag_cur && !script_in;
      end

      // shift the raw byte into the window, oldest drops out
      win_in = {req_text_byte, win_cur[WinLen-1:1]};

      // collapse whitespace runs into a single space
      prev_in   = prev_cur;
      emit      = 1'b0;
      emit_byte = kept;
      if (survives) begin
         if (is_space_byte(kept)) begin
            emit      = !prev_cur;
            emit_byte = CharSpace;
            prev_in   = 1'b1;
         end else begin
            emit    = 1'b1;
            prev_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff    <= 1'b0;
         script_ff <= 1'b0;
         prev_ff   <= 1'b0;
         win_ff    <= '0;
      end else if (accept) begin
         tag_ff    <= tag_in;
         script_ff <= script_in;
         prev_ff   <= prev_in;
         win_ff    <= win_in;
      end
   end

   mks_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept && emit),
      .in_byte   (emit_byte),
      .out_valid (rsp_valid),
      .out_byte  (rsp_plain_byte),
      .out_stall (rsp_stall),
      .status    (buf_status)
   );

   // hold input while the parked entry is occupied
   assign req_stall = buf_status.full;

   `MKS_ASSERT_NOW(a_full_implies_busy, clock, reset, buf_status.full, buf_status.busy)
   `MKS_ASSERT_NEXT(a_lt_opens_tag, clock, reset, accept && (req_text_byte == CharLt), tag_ff)
   `MKS_ASSERT_NEXT(a_gt_closes_tag, clock, reset, accept && (req_text_byte == CharGt), !tag_ff)
   `MKS_ASSERT_NEXT(a_emit_fills_buf, clock, reset, accept && emit, rsp_valid)

endmodule
